FILE: design/dq_pkg.sv
package dq_pkg;

   localparam int DEPTH = 1024;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_SIZE       = 3'd4,
      OP_EMPTY      = 3'd5,
      OP_FRONT      = 3'd6,
      OP_BACK       = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [2:0]               req_type;
      logic signed [DATA_W-1:0] push_value;
   } dq_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] result_value;
      logic [1:0]               status;
   } dq_rsp_type;

endpackage

FILE: design/double_ended_queue.sv
// Bounded double-ended queue of signed 32-bit words held in a single-port-write,
// registered-read ring memory, addressed by a head pointer and an element count.
// One request is accepted in every clock cycle, so busy stays low after reset;
// the pointer update and the memory access of a request both finish in the cycle
// that accepts it. A request that produces a result shows that result on rsp with
// rsp_valid high for exactly one cycle, the cycle right after it was accepted: the
// registered read of the ring memory sets this delay. A push that succeeds
// produces no result. The receiver must take every result in the cycle it appears.
module double_ended_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  dq_pkg::dq_req_type req,
   output logic               rsp_valid,
   output dq_pkg::dq_rsp_type rsp
);
   import dq_pkg::*;

   localparam int SUM_W = CNT_W + 1;

   logic [DATA_W-1:0] ring_store [DEPTH];

   logic [ADDR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              sel_mem_ff, sel_mem_in;
   logic [DATA_W-1:0] value_ff, value_in;
   status_type        status_ff, status_in;
   logic [DATA_W-1:0] rd_data_ff;

   logic              accept;
   logic              full;
   logic              empty;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] tail_addr;
   logic [ADDR_W-1:0] next_addr;
   logic [ADDR_W-1:0] head_dec;
   logic [ADDR_W-1:0] head_inc;

   function automatic logic [ADDR_W-1:0] slot_at(input logic [ADDR_W-1:0] base,
                                                 input logic [CNT_W-1:0] offset);
      logic [SUM_W-1:0] s;
      s = SUM_W'(base) + SUM_W'(offset);
      if (s >= SUM_W'(DEPTH)) begin
         s = s - SUM_W'(DEPTH);
      end
      return s[ADDR_W-1:0];
   endfunction

   assign busy   = 1'b0;
   assign accept = start & ~busy;
   assign full   = (count_ff == CNT_W'(DEPTH));
   assign empty  = (count_ff == '0);

   assign tail_addr = slot_at(head_ff, count_ff - CNT_W'(1));
   assign next_addr = slot_at(head_ff, count_ff);
   assign head_inc  = slot_at(head_ff, CNT_W'(1));
   assign head_dec  = (head_ff == '0) ? ADDR_W'(DEPTH - 1) : head_ff - ADDR_W'(1);

   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      wr_en        = 1'b0;
      wr_addr      = next_addr;
      rd_en        = 1'b0;
      rd_addr      = head_ff;
      rsp_valid_in = 1'b0;
      sel_mem_in   = 1'b0;
      value_in     = '0;
      status_in    = ST_OK;
      if (accept) begin
         case (op_type'(req.req_type))
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
               if (full) begin
                  rsp_valid_in = 1'b1;
                  status_in    = ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
                  if (op_type'(req.req_type) == OP_PUSH_FRONT) begin
                     wr_addr = head_dec;
                     head_in = head_dec;
                  end
               end
            end
            OP_POP_FRONT, OP_POP_BACK, OP_FRONT, OP_BACK: begin
               rsp_valid_in = 1'b1;
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  rd_en      = 1'b1;
                  sel_mem_in = 1'b1;
                  if (op_type'(req.req_type) == OP_POP_BACK ||
                      op_type'(req.req_type) == OP_BACK) begin
                     rd_addr = tail_addr;
                  end
                  if (op_type'(req.req_type) == OP_POP_FRONT) begin
                     head_in  = head_inc;
                     count_in = count_ff - CNT_W'(1);
                  end else if (op_type'(req.req_type) == OP_POP_BACK) begin
                     count_in = count_ff - CNT_W'(1);
                  end
               end
            end
            OP_SIZE: begin
               rsp_valid_in = 1'b1;
               value_in     = DATA_W'(count_ff);
            end
            OP_EMPTY: begin
               rsp_valid_in = 1'b1;
               value_in     = DATA_W'(empty);
            end
            default: begin
               rsp_valid_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_store[wr_addr] <= req.push_value;
      end
      if (rd_en) begin
         rd_data_ff <= ring_store[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         sel_mem_ff   <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         sel_mem_ff   <= sel_mem_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      status_ff <= status_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp.result_value  = sel_mem_ff ? rd_data_ff : value_ff;
   assign rsp.status        = status_ff;

endmodule

FILE: design/dq_checker.sv
module dq_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input dq_pkg::dq_req_type req,
   input logic               rsp_valid,
   input dq_pkg::dq_rsp_type rsp
);
   import dq_pkg::*;

   // A result beat only ever follows an accepted request beat.
   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && !reset))
      else $error("result beat without a request beat one cycle before");

   // Size and empty queries always answer in the next cycle with status ok.
   a_query_answers: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req.req_type == OP_SIZE || req.req_type == OP_EMPTY))
      |=> (rsp_valid && rsp.status == ST_OK))
      else $error("size or empty query did not answer with status ok");

   // The empty query answers with one or zero.
   a_empty_bool: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req.req_type == OP_EMPTY)
      |=> (rsp.result_value == 32'sd0 || rsp.result_value == 32'sd1))
      else $error("empty query answered with a value other than one or zero");

   // Pops and peeks always produce a result beat.
   a_read_answers: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req.req_type == OP_POP_FRONT || req.req_type == OP_POP_BACK ||
                          req.req_type == OP_FRONT || req.req_type == OP_BACK))
      |=> (rsp_valid && rsp.status != ST_FULL))
      else $error("pop or peek did not answer, or answered with full status");

   // A result beat never carries the unused status code.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp.status == ST_OK || rsp.status == ST_EMPTY ||
                     rsp.status == ST_FULL))
      else $error("result beat with an unused status code");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req       (req),
   .rsp_valid (rsp_valid),
   .rsp       (rsp)
);
